FILE: src/fp8c_pkg.sv
// Package for the fp8_e4m3_converter block: request kinds and conversion constants.
// No dependencies.
package fp8c_pkg;
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;
  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] EXP_CLAMP = 8'd135;
  localparam logic [22:0] FRAC_CLAMP = 23'h600000;
  localparam logic [7:0] EXP_SUB_MAX = 8'd120;
  localparam logic [7:0] EXP_SUB_BASE = 8'd141;
  localparam logic [6:0] FP8_NAN = 7'h7F;
  localparam logic [6:0] FP8_MAX = 7'h7E;
  localparam logic [30:0] F32_QNAN = 31'h7FC00000;

  typedef struct packed {
    logic        kind;
    logic        sign;
    logic [7:0]  ex;
    logic [22:0] frac;
  } fp8c_req_t;
endpackage

FILE: src/fp8c_core.sv
// Three-stage conversion pipeline between float32 and fp8 e4m3.
// Depends on fp8c_pkg.
module fp8c_core
  import fp8c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        in_valid,
  input  fp8c_req_t   in_req,
  output logic        out_valid,
  output logic [31:0] out_bits
);
  // stage 1 registers
  logic        v1;
  fp8c_req_t   r1;
  // stage 2 registers
  logic        v2;
  logic        kind2;
  logic        sign2;
  logic [1:0]  cls2;
  logic [3:0]  enc2;
  logic [3:0]  man2;
  logic [2:0]  sub2;
  logic [31:0] dec2;
  // stage 3
  logic        v3;
  logic [31:0] res3;

  localparam logic [1:0] CLS_NAN = 2'd0;
  localparam logic [1:0] CLS_BIG = 2'd1;
  localparam logic [1:0] CLS_SUB = 2'd2;
  localparam logic [1:0] CLS_NRM = 2'd3;

  logic [1:0]  cls_next;
  logic [2:0]  sub_next;
  logic [3:0]  enc_next;
  logic [3:0]  man_next;
  logic [31:0] dec_next;
  logic [7:0]  sh;
  logic [24:0] sig;
  logic [24:0] rnd;
  logic [7:0]  db;
  logic [3:0]  dex;
  logic [2:0]  dman;
  logic [4:0]  mraw;

  always_comb begin
    sig = {2'b01, r1.frac};
    sh = EXP_SUB_BASE - r1.ex;
    rnd = '0;
    sub_next = '0;
    if (r1.ex <= EXP_SUB_MAX && r1.ex != 8'd0 && sh <= 8'd24) begin
      rnd = (sig + (25'd1 << (sh[4:0] - 5'd1))) >> sh[4:0];
      sub_next = (rnd > 25'd7) ? 3'd7 : rnd[2:0];
    end
    priority if (r1.ex == EXP_ALL_ONES && r1.frac != '0) begin
      cls_next = CLS_NAN;
    end else if (r1.ex > EXP_CLAMP || (r1.ex == EXP_CLAMP && r1.frac >= FRAC_CLAMP)) begin
      cls_next = CLS_BIG;
    end else if (r1.ex <= EXP_SUB_MAX) begin
      cls_next = CLS_SUB;
    end else begin
      cls_next = CLS_NRM;
    end
    enc_next = r1.ex[3:0] - EXP_SUB_MAX[3:0];
    mraw = 5'({1'b0, r1.frac[22:19]} + 5'd1);
    man_next = mraw[4:1];
    db = r1.frac[7:0];
    dex = db[6:3];
    dman = db[2:0];
    dec_next = {db[7], 31'd0};
    if (dex == 4'hF && dman == 3'd7) begin
      dec_next = {db[7], F32_QNAN};
    end else if (dex != 4'd0) begin
      dec_next = {db[7], 8'({4'd0, dex} + EXP_SUB_MAX), dman, 20'd0};
    end else if (dman[2]) begin
      dec_next = {db[7], 8'd120, dman[1:0], 21'd0};
    end else if (dman[1]) begin
      dec_next = {db[7], 8'd119, dman[0], 22'd0};
    end else if (dman[0]) begin
      dec_next = {db[7], 8'd118, 23'd0};
    end
  end

  logic [4:0] e3;
  logic [2:0] m3;
  logic [7:0] enc_byte;
  always_comb begin
    e3 = {1'b0, enc2};
    m3 = man2[2:0];
    if (man2[3]) begin
      e3 = e3 + 5'd1;
    end
    if (e3 >= 5'd15) begin
      e3 = 5'd15;
      if (m3 > 3'd6) m3 = 3'd6;
    end
    unique case (cls2)
      CLS_NAN: enc_byte = {1'b0, FP8_NAN};
      CLS_BIG: enc_byte = {sign2, FP8_MAX};
      CLS_SUB: enc_byte = {sign2, 4'd0, sub2};
      default: enc_byte = {sign2, e3[3:0], m3};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (advance) begin
      r1 <= in_req;
      kind2 <= r1.kind;
      sign2 <= r1.sign;
      cls2 <= cls_next;
      enc2 <= enc_next;
      man2 <= man_next;
      sub2 <= sub_next;
      dec2 <= dec_next;
      res3 <= (kind2 == REQ_DECODE) ? dec2 : {24'd0, enc_byte};
    end
  end

  assign out_valid = v3;
  assign out_bits = res3;

  a_nan: assert property (@(posedge clk) disable iff (rst)
    advance && v2 && kind2 == REQ_ENCODE && cls2 == CLS_NAN |=> res3 == 32'h7F)
    else $error("nan encode wrong");
  a_enc_high: assert property (@(posedge clk) disable iff (rst)
    advance && v2 && kind2 == REQ_ENCODE |=> res3[31:8] == 24'd0)
    else $error("encode high bits set");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(res3) && $stable(v3))
    else $error("stall lost data");
endmodule

FILE: src/fp8_e4m3_converter.sv
// An accepted input word passes through the stage 1, stage 2 and stage 3 registers to the output.
// Throughput: one word per cycle; the three-stage pipeline advances whenever the
// output stage is empty or its word is taken. Reset (rst, synchronous) empties it.
// Top level of the float32 / fp8 e4m3 converter; depends on fp8c_pkg and fp8c_core.
module fp8_e4m3_converter
  import fp8c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] operand
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] result_bits
);
  logic      advance;
  fp8c_req_t req;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign req.kind = s_axis_tuser;
  assign req.sign = s_axis_tdata[31];
  assign req.ex = s_axis_tdata[30:23];
  assign req.frac = s_axis_tdata[22:0];

  fp8c_core u_core (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .in_valid(s_axis_tvalid),
    .in_req(req),
    .out_valid(m_axis_tvalid),
    .out_bits(m_axis_tdata)
  );
endmodule
